// ----- hdl/mbf_pkg.sv -----
package mbf_pkg;

   localparam int CHANNEL_W = 3;
   localparam int SAMPLE_W  = 24;
   localparam int COEF_W    = 18;
   localparam int PROD_W    = SAMPLE_W + COEF_W;
   localparam int SUM_FRAC  = 17;

   localparam logic [63:0]        Q30_ONE    = 64'h0000_0000_4000_0000;
   localparam logic [63:0]        PI_Q30     = 64'd3373259426;
   localparam logic [63:0]        TWO_PI_Q30 = 64'd6746518852;
   localparam logic signed [63:0] WIN_A      = 64'sd579820585;
   localparam logic signed [63:0] WIN_B      = 64'sd493921239;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_MAC,
      ST_DRAIN,
      ST_ABS,
      ST_SAT,
      ST_OUT
   } mbf_state_type;

   typedef struct packed {
      logic clear;
      logic op_valid;
      logic abs_step;
      logic sat_step;
   } mbf_ctrl_type;

   typedef struct packed {
      logic busy;
   } mbf_stat_type;

endpackage

// ----- hdl/mbf_ram.sv -----
module mbf_ram
   import mbf_pkg::*;
#(
   parameter int WORDS = 512,
   parameter int WIDTH = 24,
   localparam int ADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [WORDS];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/mbf_coef_rom.sv -----
module mbf_coef_rom
   import mbf_pkg::*;
#(
   parameter int TAPS        = 64,
   parameter int SAMPLE_RATE = 250,
   localparam int PTR_W = $clog2(TAPS)
) (
   input  logic                     clock,
   input  logic [PTR_W-1:0]         idx,
   output logic signed [COEF_W-1:0] coef
);

   localparam int M = TAPS - 1;
   localparam logic [63:0] DEN = 64'(2 * SAMPLE_RATE);

   function automatic logic signed [63:0] sin_q30(input logic [31:0] phase);
      logic [63:0] r;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      r = {34'd0, phase[29:0]};
      if (phase[30]) begin
         r = Q30_ONE - r;
      end
      x  = (r * TWO_PI_Q30) >> 32;
      x2 = (x * x) >> 30;
      t  = Q30_ONE;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd210;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd156;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd110;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd72;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd42;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd20;
      t  = Q30_ONE - ((x2 * t) >> 30) / 64'd6;
      s  = (x * t) >> 30;
      return phase[31] ? -$signed(s) : $signed(s);
   endfunction

   function automatic logic signed [63:0] mul_q30(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
      logic        neg;
      logic [63:0] ua;
      logic [63:0] ub;
      logic [63:0] p;
      neg = a[63] ^ b[63];
      ua  = a[63] ? $unsigned(-a) : $unsigned(a);
      ub  = b[63] ? $unsigned(-b) : $unsigned(b);
      p   = (ua * ub) >> 30;
      return neg ? -$signed(p) : $signed(p);
   endfunction

   logic signed [COEF_W-1:0] coef_table [TAPS];
   logic signed [COEF_W-1:0] coef_ff;

   for (genvar n = 0; n < TAPS; n++) begin : g_tap
      localparam int D  = 2 * n - M;
      localparam int AD = (D < 0) ? -D : D;
      localparam logic [63:0] ADU = 64'(AD);
      localparam logic [63:0] ADNZ = (AD == 0) ? 64'd1 : ADU;
      localparam logic [63:0] P2 = ((((ADU * 64'd90) % DEN) << 32) + DEN / 2) / DEN;
      localparam logic [63:0] P1 = (((ADU % DEN) << 32) + DEN / 2) / DEN;
      localparam logic signed [63:0] S2 = sin_q30(P2[31:0]);
      localparam logic signed [63:0] S1 = sin_q30(P1[31:0]);
      localparam logic signed [63:0] PIAD = $signed(PI_Q30 * ADNZ);
      localparam logic signed [63:0] HS = ((S2 - S1) * 64'sd2147483648) / PIAD;
      localparam logic signed [63:0] HC =
         $signed(((64'd178 << 30) + 64'(SAMPLE_RATE / 2)) / 64'(SAMPLE_RATE));
      localparam logic signed [63:0] H = (D == 0) ? HC : HS;
      localparam logic [63:0] PW = ((64'(n) << 32) + 64'(M / 2)) / 64'(M);
      localparam logic [31:0] PW32 = PW[31:0] + 32'h4000_0000;
      localparam logic signed [63:0] W = WIN_A - mul_q30(WIN_B, sin_q30(PW32));
      localparam logic signed [63:0] V = mul_q30(H, W);
      localparam logic [63:0] VMAG =
         (((V < 0) ? $unsigned(-V) : $unsigned(V)) + 64'd4096) >> 13;
      localparam logic signed [63:0] CV = (V < 0) ?
         ((VMAG > 64'd131072) ? -64'sd131072 : -$signed(VMAG)) :
         ((VMAG > 64'd131071) ? 64'sd131071 : $signed(VMAG));
      assign coef_table[n] = CV[COEF_W-1:0];
   end

   always_ff @(posedge clock) begin
      coef_ff <= coef_table[idx];
   end

   assign coef = coef_ff;

endmodule

// ----- hdl/mbf_mac.sv -----
module mbf_mac
   import mbf_pkg::*;
#(
   parameter int TAPS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  mbf_ctrl_type               ctrl,
   input  logic signed [SAMPLE_W-1:0] sample,
   input  logic signed [COEF_W-1:0]   coef,
   output mbf_stat_type               stat,
   output logic signed [SAMPLE_W-1:0] result
);

   localparam int ACC_W = PROD_W + $clog2(TAPS);
   localparam int RND_W = ACC_W - SUM_FRAC + 1;

   logic signed [PROD_W-1:0]   prod_ff;
   logic                       prod_v_ff;
   logic signed [ACC_W-1:0]    acc_ff;
   logic [ACC_W-1:0]           mag_ff;
   logic                       neg_ff;
   logic signed [SAMPLE_W-1:0] result_ff;

   logic [ACC_W:0]             rnd_sum;
   logic [RND_W-1:0]           rnd;
   logic signed [SAMPLE_W-1:0] sat_in;

   always_comb begin
      rnd_sum = {1'b0, mag_ff} + (ACC_W + 1)'(1 << (SUM_FRAC - 1));
      rnd     = rnd_sum[ACC_W:SUM_FRAC];
      if (neg_ff) begin
         if (rnd > RND_W'(1 << (SAMPLE_W - 1))) begin
            sat_in = {1'b1, {(SAMPLE_W - 1){1'b0}}};
         end else begin
            sat_in = -$signed(rnd[SAMPLE_W-1:0]);
         end
      end else begin
         if (rnd > RND_W'((1 << (SAMPLE_W - 1)) - 1)) begin
            sat_in = {1'b0, {(SAMPLE_W - 1){1'b1}}};
         end else begin
            sat_in = $signed(rnd[SAMPLE_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_v_ff <= 1'b0;
      end else begin
         prod_v_ff <= ctrl.op_valid;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= sample * coef;
      if (ctrl.clear) begin
         acc_ff <= '0;
      end else if (prod_v_ff) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (ctrl.abs_step) begin
         mag_ff <= acc_ff[ACC_W-1] ? $unsigned(-acc_ff) : $unsigned(acc_ff);
         neg_ff <= acc_ff[ACC_W-1];
      end
      if (ctrl.sat_step) begin
         result_ff <= sat_in;
      end
   end

   assign stat.busy = prod_v_ff;
   assign result    = result_ff;

endmodule

// ----- hdl/multichannel_bandpass_fir.sv -----
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_channel, req_sample
// rsp      out        rsp_valid/rsp_ready  rsp_out_channel, rsp_filtered
//
// each item is processed by the single multiply-accumulate unit, which walks
// the channel's delay line one tap a cycle; new items are accepted only when idle
// an item on a channel not below CHANNELS skips the delay line and yields zero
// after reset the delay memory and head pointers are cleared, req_ready low
// the result register lets the next item be accepted while a result waits
module multichannel_bandpass_fir
   import mbf_pkg::*;
#(
   parameter int TAPS        = 64,
   parameter int CHANNELS    = 8,
   parameter int SAMPLE_RATE = 250
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [CHANNEL_W-1:0]       req_channel,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [CHANNEL_W-1:0]       rsp_out_channel,
   output logic signed [SAMPLE_W-1:0] rsp_filtered
);

   localparam int WORDS  = CHANNELS * TAPS;
   localparam int ADDR_W = $clog2(WORDS);
   localparam int PTR_W  = $clog2(TAPS);
   localparam int HEAD_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   mbf_state_type state_ff, state_in;

   logic [ADDR_W-1:0]          clr_cnt_ff, clr_cnt_in;
   logic [CHANNEL_W-1:0]       ch_ff, ch_in;
   logic                       bad_ff, bad_in;
   logic signed [SAMPLE_W-1:0] sample_ff, sample_in;
   logic [ADDR_W-1:0]          base_ff, base_in;
   logic [PTR_W-1:0]           rptr_ff, rptr_in;
   logic [PTR_W-1:0]           idx_ff, idx_in;
   logic                       rd_v_ff, rd_v_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [CHANNEL_W-1:0]       rsp_channel_ff, rsp_channel_in;
   logic signed [SAMPLE_W-1:0] rsp_filtered_ff, rsp_filtered_in;

   logic                       accept;
   logic                       ch_ok;
   logic                       clr_last;
   logic                       tap_last;
   logic                       out_free;
   logic [PTR_W-1:0]           new_head;

   logic                       mem_we;
   logic [ADDR_W-1:0]          mem_waddr;
   logic [SAMPLE_W-1:0]        mem_wdata;
   logic [ADDR_W-1:0]          mem_raddr;
   logic [SAMPLE_W-1:0]        mem_rdata;

   logic                       head_we;
   logic [HEAD_W-1:0]          head_waddr;
   logic [PTR_W-1:0]           head_wdata;
   logic [HEAD_W-1:0]          head_raddr;
   logic [PTR_W-1:0]           head_rdata;

   logic                       issue;
   mbf_ctrl_type               ctrl;
   mbf_stat_type               stat;
   logic signed [COEF_W-1:0]   coef;
   logic signed [SAMPLE_W-1:0] mac_result;

   mbf_ram #(
      .WORDS (WORDS),
      .WIDTH (SAMPLE_W)
   ) u_delay_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   mbf_ram #(
      .WORDS (CHANNELS),
      .WIDTH (PTR_W)
   ) u_head_ram (
      .clock   (clock),
      .wr_en   (head_we),
      .wr_addr (head_waddr),
      .wr_data (head_wdata),
      .rd_addr (head_raddr),
      .rd_data (head_rdata)
   );

   mbf_coef_rom #(
      .TAPS        (TAPS),
      .SAMPLE_RATE (SAMPLE_RATE)
   ) u_coef_rom (
      .clock (clock),
      .idx   (idx_ff),
      .coef  (coef)
   );

   mbf_mac #(
      .TAPS (TAPS)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (ctrl),
      .sample ($signed(mem_rdata)),
      .coef   (coef),
      .stat   (stat),
      .result (mac_result)
   );

   assign accept   = req_valid && req_ready;
   assign ch_ok    = 32'(req_channel) < CHANNELS;
   assign clr_last = clr_cnt_ff == ADDR_W'(WORDS - 1);
   assign tap_last = idx_ff == PTR_W'(TAPS - 1);
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign new_head = (head_rdata == PTR_W'(TAPS - 1)) ? '0 : head_rdata + 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               state_in = ch_ok ? ST_WRITE : ST_OUT;
            end
         end
         ST_WRITE: state_in = ST_MAC;
         ST_MAC: begin
            if (tap_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!rd_v_ff && !stat.busy) begin
               state_in = ST_ABS;
            end
         end
         ST_ABS: state_in = ST_SAT;
         ST_SAT: state_in = ST_OUT;
         ST_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and memory control
   always_comb begin
      req_ready     = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = base_ff + ADDR_W'(new_head);
      mem_wdata     = sample_ff;
      mem_raddr     = base_ff + ADDR_W'(rptr_ff);
      head_we       = 1'b0;
      head_waddr    = HEAD_W'(ch_ff);
      head_wdata    = new_head;
      head_raddr    = HEAD_W'(req_channel);
      issue         = 1'b0;
      ctrl.clear    = 1'b0;
      ctrl.op_valid = rd_v_ff;
      ctrl.abs_step = 1'b0;
      ctrl.sat_step = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we     = 1'b1;
            mem_waddr  = clr_cnt_ff;
            mem_wdata  = '0;
            head_we    = 32'(clr_cnt_ff) < CHANNELS;
            head_waddr = HEAD_W'(clr_cnt_ff);
            head_wdata = '0;
         end
         ST_IDLE:  req_ready = 1'b1;
         ST_WRITE: begin
            mem_we     = 1'b1;
            head_we    = 1'b1;
            ctrl.clear = 1'b1;
         end
         ST_MAC:   issue = 1'b1;
         ST_ABS:   ctrl.abs_step = 1'b1;
         ST_SAT:   ctrl.sat_step = 1'b1;
         default: begin
         end
      endcase
   end

   // datapath next values
   always_comb begin
      clr_cnt_in      = clr_cnt_ff;
      ch_in           = ch_ff;
      bad_in          = bad_ff;
      sample_in       = sample_ff;
      base_in         = base_ff;
      rptr_in         = rptr_ff;
      idx_in          = idx_ff;
      rd_v_in         = issue;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_channel_in  = rsp_channel_ff;
      rsp_filtered_in = rsp_filtered_ff;
      if (state_ff == ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      if (accept) begin
         ch_in     = req_channel;
         bad_in    = !ch_ok;
         sample_in = req_sample;
         base_in   = ADDR_W'(req_channel) * ADDR_W'(TAPS);
      end
      if (state_ff == ST_WRITE) begin
         rptr_in = new_head;
         idx_in  = '0;
      end
      if (issue) begin
         rptr_in = (rptr_ff == '0) ? PTR_W'(TAPS - 1) : rptr_ff - 1'b1;
         idx_in  = idx_ff + 1'b1;
      end
      if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in    = 1'b1;
         rsp_channel_in  = ch_ff;
         rsp_filtered_in = bad_ff ? '0 : mac_result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         rd_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         rd_v_ff      <= rd_v_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff           <= ch_in;
      bad_ff          <= bad_in;
      sample_ff       <= sample_in;
      base_ff         <= base_in;
      rptr_ff         <= rptr_in;
      idx_ff          <= idx_in;
      rsp_channel_ff  <= rsp_channel_in;
      rsp_filtered_ff <= rsp_filtered_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_channel_ff;
   assign rsp_filtered    = rsp_filtered_ff;

endmodule
